// ----- rtl/core/klk_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// klk_pkg
// Types, codes and sizes shared by the keypad code lock modules.
// ----------------------------------------------------------------------------
package klk_pkg;

  localparam int CODE_DIGITS = 6;
  localparam int CNT_W       = $clog2(CODE_DIGITS + 1);
  localparam int DIGIT_W     = 4;

  localparam logic [DIGIT_W-1:0] KEY_MIN = 4'd1;
  localparam logic [DIGIT_W-1:0] KEY_MAX = 4'd9;

  typedef enum logic [1:0] {
    FUNC_KEY    = 2'd0,
    FUNC_VERIFY = 2'd1,
    FUNC_CHANGE = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_UNLOCKED = 3'd1,
    ST_DENIED   = 3'd2,
    ST_OLD_OK   = 3'd3,
    ST_CHANGED  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    SM_IDLE   = 2'd0,
    SM_VERIFY = 2'd1,
    SM_OLD    = 2'd2,
    SM_NEW    = 2'd3
  } session_t;

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_VERIFY = 4'b0010,
    MODE_OLD    = 4'b0100,
    MODE_NEW    = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [DIGIT_W-1:0] key_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] digits_entered;
    logic [1:0] session_mode;
  } out_item_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] key;
    logic               commit;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/core/keypad_code_lock.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_code_lock
// Six-digit keypad code lock: verifies an entered code or changes it after
// the old code is checked, using a row of digit cells with a match chain.
// ----------------------------------------------------------------------------
// an accepted item's result is registered in the output or skid register
// throughput: one item per cycle while in_stall is low; a two-entry output
//   stage (register + skid) keeps input open while one result waits
// the match decision is an and-chain through the digit cells in the same cycle
// reset: synchronous, mode to idle; count, entered and stored digits to zero
module keypad_code_lock (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire klk_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output klk_pkg::out_item_t      out_item
);

  localparam int N = klk_pkg::CODE_DIGITS;

  klk_pkg::mode_t                mode_r, mode_nxt;
  logic [klk_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic                          out_v_r, skid_v_r;
  klk_pkg::out_item_t            out_r, skid_r;
  klk_pkg::out_item_t            res;
  klk_pkg::status_t              status;
  klk_pkg::session_t             sess;
  klk_pkg::cell_ctl_t            ctl;
  logic [N-1:0]                  wr_en;
  logic [N:0]                    chain;
  logic                          acc, digit, last, out_fire;

  assign in_stall  = skid_v_r;
  assign acc       = in_valid & ~in_stall;
  assign out_fire  = out_v_r & ~out_stall;
  assign out_valid = out_v_r;
  assign out_item  = out_r;

  assign digit = acc && (in_item.func == klk_pkg::FUNC_KEY)
              && (in_item.key_value >= klk_pkg::KEY_MIN)
              && (in_item.key_value <= klk_pkg::KEY_MAX)
              && (mode_r != klk_pkg::MODE_IDLE);
  assign last  = digit && (count_r == klk_pkg::CNT_W'(N - 1));

  assign ctl.key    = in_item.key_value;
  assign ctl.commit = last && (mode_r == klk_pkg::MODE_NEW);

  assign chain[0] = 1'b1;

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_cell
      assign wr_en[k] = digit && (count_r == klk_pkg::CNT_W'(k));
      klk_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .wr_en     (wr_en[k]),
        .match_in  (chain[k]),
        .match_out (chain[k+1])
      );
    end
  endgenerate

  always_comb begin
    mode_nxt  = mode_r;
    count_nxt = count_r;
    status    = klk_pkg::ST_NONE;
    if (acc && in_item.func == klk_pkg::FUNC_VERIFY) begin
      mode_nxt  = klk_pkg::MODE_VERIFY;
      count_nxt = '0;
    end else if (acc && in_item.func == klk_pkg::FUNC_CHANGE) begin
      mode_nxt  = klk_pkg::MODE_OLD;
      count_nxt = '0;
    end else if (last) begin
      count_nxt = '0;
      mode_nxt  = klk_pkg::MODE_IDLE;
      unique case (mode_r)
        klk_pkg::MODE_VERIFY: begin
          status = chain[N] ? klk_pkg::ST_UNLOCKED : klk_pkg::ST_DENIED;
        end
        klk_pkg::MODE_OLD: begin
          if (chain[N]) begin
            status   = klk_pkg::ST_OLD_OK;
            mode_nxt = klk_pkg::MODE_NEW;
          end else begin
            status = klk_pkg::ST_DENIED;
          end
        end
        klk_pkg::MODE_NEW: begin
          status = klk_pkg::ST_CHANGED;
        end
        default: begin
          status   = klk_pkg::ST_NONE;
          mode_nxt = mode_r;
        end
      endcase
    end else if (digit) begin
      count_nxt = count_r + klk_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    unique case (mode_nxt)
      klk_pkg::MODE_IDLE:   sess = klk_pkg::SM_IDLE;
      klk_pkg::MODE_VERIFY: sess = klk_pkg::SM_VERIFY;
      klk_pkg::MODE_OLD:    sess = klk_pkg::SM_OLD;
      klk_pkg::MODE_NEW:    sess = klk_pkg::SM_NEW;
      default:              sess = klk_pkg::SM_IDLE;
    endcase
    res.status         = status;
    res.digits_entered = 3'(count_nxt);
    res.session_mode   = sess;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= klk_pkg::MODE_IDLE;
      count_r  <= '0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
      if (out_fire || !out_v_r) begin
        if (skid_v_r) begin
          out_v_r  <= 1'b1;
          skid_v_r <= 1'b0;
        end else begin
          out_v_r <= acc;
        end
      end else if (acc) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  // payload of output stage
  always_ff @(posedge clk) begin
    if (out_fire || !out_v_r) begin
      if (skid_v_r) begin
        out_r <= skid_r;
      end else if (acc) begin
        out_r <= res;
      end
    end else if (acc) begin
      skid_r <= res;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds an item while output register is empty");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < klk_pkg::CNT_W'(N))
    else $error("entry count out of range");

  a_begin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_item.func == klk_pkg::FUNC_VERIFY ||
             in_item.func == klk_pkg::FUNC_CHANGE)) |=> (count_r == '0))
    else $error("begin command did not clear entry count");

  a_idle_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == klk_pkg::MODE_IDLE) |-> (count_r == '0))
    else $error("entry count nonzero while idle");

endmodule
`default_nettype wire

// ----- rtl/core/klk_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// klk_cell
// One digit position: holds the entered digit and the stored code digit and
// extends the match chain from its neighbor.
// ----------------------------------------------------------------------------
module klk_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire klk_pkg::cell_ctl_t ctl,
  input  wire logic               wr_en,
  input  wire logic               match_in,
  output logic                    match_out
);

  logic [klk_pkg::DIGIT_W-1:0] entry_r, entry_nxt;
  logic [klk_pkg::DIGIT_W-1:0] stored_r, stored_nxt;

  always_comb begin
    entry_nxt  = wr_en ? ctl.key : entry_r;
    stored_nxt = ctl.commit ? entry_nxt : stored_r;
    match_out  = match_in & (entry_nxt == stored_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r  <= '0;
      stored_r <= '0;
    end else begin
      entry_r  <= entry_nxt;
      stored_r <= stored_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- tb/keypad_code_lock_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_code_lock_checker
// Watches both channels of the code lock. Each accepted key or command item
// is run through a local model of the lock sessions. The status, digit count
// and session it should produce are queued, and each accepted result is
// compared against the oldest queued entry.
// ----------------------------------------------------------------------------
module keypad_code_lock_checker
  import klk_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending
);

  session_t           lock_session;
  logic [DIGIT_W-1:0] typed_code  [CODE_DIGITS];
  logic [DIGIT_W-1:0] stored_code [CODE_DIGITS];
  int                 typed_count;
  out_item_t          lock_results [$];

  function automatic out_item_t lock_step(input in_item_t item);
    out_item_t res;
    status_t   st;
    logic      same;
    st = ST_NONE;
    case (func_t'(item.func))
      FUNC_VERIFY: begin
        lock_session = SM_VERIFY;
        typed_count  = 0;
      end
      FUNC_CHANGE: begin
        lock_session = SM_OLD;
        typed_count  = 0;
      end
      FUNC_KEY: begin
        if (item.key_value >= KEY_MIN && item.key_value <= KEY_MAX &&
            lock_session != SM_IDLE) begin
          typed_code[typed_count] = item.key_value;
          typed_count++;
          if (typed_count == CODE_DIGITS) begin
            typed_count = 0;
            same = 1'b1;
            for (int k = 0; k < CODE_DIGITS; k++) begin
              if (typed_code[k] != stored_code[k]) same = 1'b0;
            end
            case (lock_session)
              SM_VERIFY: begin
                if (same) st = ST_UNLOCKED;
                else st = ST_DENIED;
                lock_session = SM_IDLE;
              end
              SM_OLD: begin
                if (same) begin
                  st = ST_OLD_OK;
                  lock_session = SM_NEW;
                end else begin
                  st = ST_DENIED;
                  lock_session = SM_IDLE;
                end
              end
              default: begin
                stored_code  = typed_code;
                st           = ST_CHANGED;
                lock_session = SM_IDLE;
              end
            endcase
          end
        end
      end
      default: ;
    endcase
    res.status         = st;
    res.digits_entered = 3'(typed_count);
    res.session_mode   = lock_session;
    return res;
  endfunction

  function void check_field(input string name, input logic [3:0] want, input logic [3:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      lock_session = SM_IDLE;
      typed_count  = 0;
      for (int k = 0; k < CODE_DIGITS; k++) begin
        typed_code[k]  = '0;
        stored_code[k] = '0;
      end
      lock_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (lock_results.size() == 0) begin
          $error("result with no item waiting: status %0d", out_item.status);
          fail_count++;
        end else begin
          want = lock_results.pop_front();
          check_field("status", 4'(want.status), 4'(out_item.status));
          check_field("digits_entered", 4'(want.digits_entered), 4'(out_item.digits_entered));
          check_field("session_mode", 4'(want.session_mode), 4'(out_item.session_mode));
        end
      end
      if (in_valid && !in_stall) lock_results.push_back(lock_step(in_item));
    end
    pending = lock_results.size();
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives key and command items into the code lock: a short directed set of
// idle keys, stray keys, restarts and full entries, then random verify and
// change sessions mixed with broken entries and noise. Both sides idle at
// random and the output is held off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
  import klk_pkg::*;

  localparam int ITEM_TARGET = 1150;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 60;
  localparam int DRAIN       = 8;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  int fail_count;
  int pending;
  int items_sent    = 0;
  int begins_sent   = 0;
  int results_taken = 0;
  int idle_cycles   = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  keypad_code_lock dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  keypad_code_lock_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // every fourth stretch of 40 runs without gaps
  function automatic int draw_wait(input int n);
    if ((n / 40) % 4 == 3) return 0;
    return $urandom_range(0, 3);
  endfunction

  function automatic logic [DIGIT_W-1:0] random_digit();
    return DIGIT_W'($urandom_range(KEY_MIN, KEY_MAX));
  endfunction

  function automatic logic [DIGIT_W-1:0] random_stray_key();
    int k;
    k = $urandom_range(0, 6);
    if (k == 0) return '0;
    return DIGIT_W'(k + 9);
  endfunction

  task automatic send_item(input func_t f, input logic [DIGIT_W-1:0] k);
    int gap;
    gap = draw_wait(items_sent);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= {f, k};
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    items_sent++;
    if (f == FUNC_VERIFY || f == FUNC_CHANGE) begin
      begins_sent++;
    end
  endtask

  task automatic send_stray();
    if ($urandom_range(1)) send_item(FUNC_NONE, DIGIT_W'($urandom_range(15)));
    else send_item(FUNC_KEY, random_stray_key());
  endtask

  task automatic send_session(input int digits, input int noise_pct);
    if ($urandom_range(1)) send_item(FUNC_VERIFY, DIGIT_W'($urandom_range(15)));
    else send_item(FUNC_CHANGE, DIGIT_W'($urandom_range(15)));
    for (int d = 0; d < digits; d++) begin
      if ($urandom_range(99) < noise_pct) send_stray();
      send_item(FUNC_KEY, random_digit());
    end
  endtask

  task automatic take_results();
    int w;
    bit held_long;
    held_long = 1'b0;
    forever begin
      if (!held_long && results_taken == 300) begin
        held_long = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        w = draw_wait(results_taken);
        if (w > 0) begin
          out_stall <= 1'b1;
          repeat (w) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
      results_taken++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int r;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    fork
      take_results();
    join_none

    // idle keys, stray keys and an undefined command
    send_item(FUNC_KEY, 4'd0);
    send_item(FUNC_KEY, 4'd15);
    send_item(FUNC_KEY, 4'd5);
    send_item(FUNC_NONE, 4'd9);
    // partial verify, then restart drops it
    send_item(FUNC_VERIFY, 4'd0);
    send_item(FUNC_KEY, 4'd1);
    send_item(FUNC_KEY, 4'd10);
    send_item(FUNC_NONE, 4'd3);
    send_item(FUNC_VERIFY, 4'd15);
    for (int d = 0; d < CODE_DIGITS; d++) send_item(FUNC_KEY, DIGIT_W'(9 - d));
    // partial change, restart, full old-code entry that does not match
    send_item(FUNC_CHANGE, 4'd6);
    send_item(FUNC_KEY, 4'd4);
    send_item(FUNC_CHANGE, 4'd0);
    for (int d = 0; d < CODE_DIGITS; d++) send_item(FUNC_KEY, DIGIT_W'(d + 1));

    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(99);
      if (r < 60) send_session(CODE_DIGITS, 10);
      else if (r < 80) send_session($urandom_range(1, CODE_DIGITS - 1), 20);
      else if (r < 90) send_item(FUNC_KEY, random_digit());
      else send_stray();
    end
    in_valid <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (DRAIN) @(posedge clk);
    $display("covered %0d items with %0d session starts and %0d results,",
             items_sent, begins_sent, results_taken);
    $display("with random gaps on both sides and one long output hold");
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
